// ----- rtl/core/qte_pkg.sv -----
package qte_pkg;

    // fixed internal widths
    localparam int P_W      = 32;   // component product in q.30
    localparam int SUM_W    = 36;   // atan2 operands in q.30
    localparam int CORD_W   = 44;   // cordic datapath
    localparam int ANG_W    = 32;   // angle accumulator, 2^32 = 2*pi
    localparam int BAM_W    = 16;   // output binary angle
    localparam int RAD_W    = 62;   // square root working width
    localparam int ROOT_W   = 31;   // square root result, one bit per stage
    localparam int LANES    = 3;
    localparam int NORM_EXP = 40;   // operands scaled until max magnitude >= 2^40
    localparam int Q30_EXP  = 30;

    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    localparam logic [ANG_W-1:0] ANG_PI          = 32'h8000_0000;
    localparam logic [ANG_W-1:0] ANG_HALF_PI     = 32'h4000_0000;
    localparam logic [ANG_W-1:0] ANG_NEG_HALF_PI = 32'hC000_0000;
    localparam logic [ANG_W-1:0] ANG_ROUND       = 32'h0000_8000;

    typedef struct packed {
        logic signed [SUM_W-1:0] roll_y;
        logic signed [SUM_W-1:0] roll_x;
        logic signed [SUM_W-1:0] yaw_y;
        logic signed [SUM_W-1:0] yaw_x;
        logic signed [P_W-1:0]   sin_p;
        logic                    clamp;
    } t_ops;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [ANG_W-1:0] atan_tab(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0029;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0003;
            5'd29:   v = 32'h0000_0001;
            5'd30:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/quaternion_to_euler_top.sv -----
// quaternion to euler angle converter
// input stream: one quaternion per transfer, four signed q1.(w-1) components
//   (scalar, i, j, k) packed in s_axis_tdata from the low bits up
// output stream: roll, pitch, yaw as signed 16-bit binary angles (32768 = pi)
//   in m_axis_tdata, and m_axis_tuser set when the pitch sine exceeded one
//   and was clamped, in which case pitch is exactly +-pi/2
// pipeline: 3 stages of products and sums, 31 square root stages (one root
//   bit each), then a 4 + CORDIC_STAGES stage cordic with three parallel lanes
// throughput: one transfer per cycle in and out while m_axis_tready is
//   high; every stage has its own valid bit and loads whenever it is
//   empty or its successor moves on
// stall: when m_axis_tready is low the result holds in the output register,
//   the stages behind it keep filling their empty slots, and s_axis_tready
//   drops only once the whole pipeline is full; nothing is lost or repeated
// reset: synchronous, active low; clears all valid bits, data is left as is
module quaternion_to_euler_top #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // quat_scalar, quat_i, quat_j, quat_k, zero pad to whole bytes
    input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle
    output logic [3*qte_pkg::BAM_W-1:0]                  m_axis_tdata,
    // pitch_clamped
    output logic [0:0]                                   m_axis_tuser
);
    import qte_pkg::*;

    localparam int W = COMPONENT_WIDTH;

    // front end to square root
    logic             w_fr_valid, w_fr_ready;
    t_ops             w_fr_ops;
    logic [RAD_W-1:0] w_fr_rad;

    // square root to cordic
    logic              w_sq_valid, w_sq_ready;
    logic [ROOT_W-1:0] w_sq_root;
    t_ops              w_sq_ops;

    logic [LANES-1:0][SUM_W-1:0] w_cy, w_cx;
    logic [LANES-1:0][BAM_W-1:0] w_ang;

    // component products, operand sums and the pitch radicand
    qte_front #(
        .W (W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_q0    (s_axis_tdata[0*W +: W]),
        .i_q1    (s_axis_tdata[1*W +: W]),
        .i_q2    (s_axis_tdata[2*W +: W]),
        .i_q3    (s_axis_tdata[3*W +: W]),
        .o_valid (w_fr_valid),
        .i_ready (w_fr_ready),
        .o_ops   (w_fr_ops),
        .o_rad   (w_fr_rad)
    );

    // cos(pitch) = sqrt(1 - s*s); roll and yaw operands ride along
    qte_isqrt #(
        .SIDE_W ($bits(t_ops))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_rad   (w_fr_rad),
        .i_side  (w_fr_ops),
        .o_valid (w_sq_valid),
        .i_ready (w_sq_ready),
        .o_root  (w_sq_root),
        .o_side  (w_sq_ops)
    );

    // three atan2 lanes; pitch is atan2(s, sqrt(1 - s*s))
    always_comb begin
        w_cy[LANE_ROLL]  = w_sq_ops.roll_y;
        w_cx[LANE_ROLL]  = w_sq_ops.roll_x;
        w_cy[LANE_PITCH] = SUM_W'(w_sq_ops.sin_p);
        w_cx[LANE_PITCH] = SUM_W'(w_sq_root);
        w_cy[LANE_YAW]   = w_sq_ops.yaw_y;
        w_cx[LANE_YAW]   = w_sq_ops.yaw_x;
    end

    qte_cordic #(
        .ITER   (CORDIC_STAGES),
        .SIDE_W (1)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .o_ready (w_sq_ready),
        .i_y     (w_cy),
        .i_x     (w_cx),
        .i_side  (w_sq_ops.clamp),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_ang   (w_ang),
        .o_side  (m_axis_tuser)
    );

    // roll in the low bits, yaw in the high bits
    assign m_axis_tdata = w_ang;

endmodule

// ----- rtl/core/qte_front.sv -----
module qte_front #(
    parameter int W = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [W-1:0]          i_q0,
    input  logic signed [W-1:0]          i_q1,
    input  logic signed [W-1:0]          i_q2,
    input  logic signed [W-1:0]          i_q3,
    output logic                         o_valid,
    input  logic                         i_ready,
    output qte_pkg::t_ops                o_ops,
    output logic [qte_pkg::RAD_W-1:0]    o_rad
);
    import qte_pkg::*;

    localparam int PF  = 2 * (W - 1);
    localparam int SHL = (PF < Q30_EXP) ? Q30_EXP - PF : 0;
    localparam int SHR = (PF > Q30_EXP) ? PF - Q30_EXP : 0;
    localparam logic signed [SUM_W-1:0] Q_ONE = SUM_W'(2 ** Q30_EXP);
    localparam int NS = 3;

    // product brought exactly to q.30, floor when bits are dropped
    function automatic logic signed [P_W-1:0] f_q30(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        logic signed [63:0]    pe;
        p  = a * b;
        pe = 64'(p);
        pe = (pe <<< SHL) >>> SHR;
        return pe[P_W-1:0];
    endfunction

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    logic signed [P_W-1:0] r_p00, r_p01, r_p02, r_p03, r_p11;
    logic signed [P_W-1:0] r_p12, r_p13, r_p22, r_p23, r_p33;
    t_ops                  r_ops2, n_ops2, r_ops3;
    logic [RAD_W-1:0]      r_rad, n_rad;
    logic signed [SUM_W-1:0] w_sraw;
    logic [ROOT_W-1:0]     w_abs;
    logic [RAD_W-1:0]      w_sq;

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_ops   = r_ops3;
    assign o_rad   = r_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // stage 1: the ten component products
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_p00 <= f_q30(i_q0, i_q0);
            r_p01 <= f_q30(i_q0, i_q1);
            r_p02 <= f_q30(i_q0, i_q2);
            r_p03 <= f_q30(i_q0, i_q3);
            r_p11 <= f_q30(i_q1, i_q1);
            r_p12 <= f_q30(i_q1, i_q2);
            r_p13 <= f_q30(i_q1, i_q3);
            r_p22 <= f_q30(i_q2, i_q2);
            r_p23 <= f_q30(i_q2, i_q3);
            r_p33 <= f_q30(i_q3, i_q3);
        end
    end

    // stage 2: operand sums, sine of pitch clamped to +-1
    assign w_sraw = (SUM_W'(r_p02) - SUM_W'(r_p13)) <<< 1;

    always_comb begin
        n_ops2.roll_y = (SUM_W'(r_p23) + SUM_W'(r_p01)) <<< 1;
        n_ops2.roll_x = SUM_W'(r_p00) - SUM_W'(r_p11) - SUM_W'(r_p22) + SUM_W'(r_p33);
        n_ops2.yaw_y  = (SUM_W'(r_p12) + SUM_W'(r_p03)) <<< 1;
        n_ops2.yaw_x  = SUM_W'(r_p00) + SUM_W'(r_p11) - SUM_W'(r_p22) - SUM_W'(r_p33);
        if (w_sraw > Q_ONE) begin
            n_ops2.sin_p = Q_ONE[P_W-1:0];
            n_ops2.clamp = 1'b1;
        end else if (w_sraw < -Q_ONE) begin
            n_ops2.sin_p = -Q_ONE[P_W-1:0];
            n_ops2.clamp = 1'b1;
        end else begin
            n_ops2.sin_p = w_sraw[P_W-1:0];
            n_ops2.clamp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_ops2 <= n_ops2;
        end
    end

    // stage 3: radicand 1 - s*s in q.60
    assign w_abs = r_ops2.sin_p[P_W-1] ? ROOT_W'(-r_ops2.sin_p) : ROOT_W'(r_ops2.sin_p);
    assign w_sq  = RAD_W'(w_abs) * RAD_W'(w_abs);
    assign n_rad = (RAD_W'(1) << (2 * Q30_EXP)) - w_sq;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_ops3 <= r_ops2;
            r_rad  <= n_rad;
        end
    end

endmodule

// ----- rtl/core/qte_isqrt.sv -----
module qte_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [qte_pkg::RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [qte_pkg::ROOT_W-1:0]    o_root,
    output logic [SIDE_W-1:0]             o_side
);
    import qte_pkg::*;

    // one result bit per stage, radicand below 2^61
    localparam int NS = ROOT_W;

    logic [NS-1:0]     r_v;
    logic [NS:0]       w_rdy;
    logic [RAD_W-1:0]  r_rem  [NS];
    logic [RAD_W-1:0]  r_res  [NS];
    logic [SIDE_W-1:0] r_side [NS];
    logic [RAD_W-1:0]  n_rem  [NS];
    logic [RAD_W-1:0]  n_res  [NS];
    logic [RAD_W-1:0]  w_rem_in [NS];
    logic [RAD_W-1:0]  w_res_in [NS];
    logic [SIDE_W-1:0] w_side_in [NS];

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_root  = r_res[NS-1][ROOT_W-1:0];
    assign o_side  = r_side[NS-1];

    always_comb begin
        w_rem_in[0]  = i_rad;
        w_res_in[0]  = '0;
        w_side_in[0] = i_side;
        for (int j = 1; j < NS; j++) begin
            w_rem_in[j]  = r_rem[j-1];
            w_res_in[j]  = r_res[j-1];
            w_side_in[j] = r_side[j-1];
        end
    end

    always_comb begin
        logic [RAD_W-1:0] v_bit;
        logic [RAD_W-1:0] v_sum;
        for (int j = 0; j < NS; j++) begin
            v_bit = RAD_W'(1) << (2 * (NS - 1 - j));
            v_sum = w_res_in[j] + v_bit;
            if (w_rem_in[j] >= v_sum) begin
                n_rem[j] = w_rem_in[j] - v_sum;
                n_res[j] = (w_res_in[j] >> 1) + v_bit;
            end else begin
                n_rem[j] = w_rem_in[j];
                n_res[j] = w_res_in[j] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j < NS; j++) begin
                if (w_rdy[j]) begin
                    r_v[j] <= (j == 0) ? i_valid : r_v[(j == 0) ? 0 : j - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NS; j++) begin
            if (w_rdy[j]) begin
                r_rem[j]  <= n_rem[j];
                r_res[j]  <= n_res[j];
                r_side[j] <= w_side_in[j];
            end
        end
    end

endmodule

// ----- rtl/core/qte_cordic.sv -----
module qte_cordic #(
    parameter int ITER   = 16,
    parameter int SIDE_W = 1
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    output logic                                             o_ready,
    input  logic [qte_pkg::LANES-1:0][qte_pkg::SUM_W-1:0]    i_y,
    input  logic [qte_pkg::LANES-1:0][qte_pkg::SUM_W-1:0]    i_x,
    input  logic [SIDE_W-1:0]                                i_side,
    output logic                                             o_valid,
    input  logic                                             i_ready,
    output logic [qte_pkg::LANES-1:0][qte_pkg::BAM_W-1:0]    o_ang,
    output logic [SIDE_W-1:0]                                o_side
);
    import qte_pkg::*;

    // pre-rotate, two scaling stages, ITER micro-rotations, rounding
    localparam int NS  = ITER + 4;
    localparam int NXY = ITER + 2;
    localparam int NAC = ITER + 3;

    typedef struct packed {
        logic [CORD_W-1:0]        m;
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
    } t_nrm;

    function automatic t_nrm f_nrm(input t_nrm v, input int sh);
        t_nrm r;
        r = v;
        if (v.m < (CORD_W'(1) << (NORM_EXP + 1 - sh))) begin
            r.m = v.m << sh;
            r.x = v.x <<< sh;
            r.y = v.y <<< sh;
        end
        return r;
    endfunction

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    logic signed [CORD_W-1:0] r_x   [LANES][NXY];
    logic signed [CORD_W-1:0] r_y   [LANES][NXY];
    logic [ANG_W-1:0]         r_acc [LANES][NAC];
    logic                     r_fix [LANES][NXY];
    logic [CORD_W-1:0]        r_m   [LANES][2];
    logic [BAM_W-1:0]         r_ang [LANES];
    logic [SIDE_W-1:0]        r_side [NS];

    logic signed [CORD_W-1:0] n_x   [LANES][NXY];
    logic signed [CORD_W-1:0] n_y   [LANES][NXY];
    logic [ANG_W-1:0]         n_acc [LANES][NAC];
    logic                     n_fix [LANES][NXY];
    logic [CORD_W-1:0]        n_m   [LANES][2];
    logic [BAM_W-1:0]         n_ang [LANES];

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_side  = r_side[NS-1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_ang[l] = r_ang[l];
        end
    end

    always_comb begin
        logic signed [CORD_W-1:0] vx, vy, vxs, vys;
        logic [CORD_W-1:0]        vay;
        logic [ANG_W-1:0]         vrnd;
        t_nrm                     vn;
        n_x   = r_x;
        n_y   = r_y;
        n_acc = r_acc;
        n_fix = r_fix;
        n_m   = r_m;
        for (int l = 0; l < LANES; l++) begin
            // pre-rotation and exact special angles
            vx = CORD_W'($signed(i_x[l]));
            vy = CORD_W'($signed(i_y[l]));
            n_acc[l][0] = '0;
            n_fix[l][0] = 1'b0;
            if (vx == 0) begin
                n_fix[l][0] = 1'b1;
                if (vy > 0) begin
                    n_acc[l][0] = ANG_HALF_PI;
                end else if (vy < 0) begin
                    n_acc[l][0] = ANG_NEG_HALF_PI;
                end
            end else if (vx < 0) begin
                vx = -vx;
                vy = -vy;
                n_acc[l][0] = ANG_PI;
            end
            vay = vy[CORD_W-1] ? CORD_W'(-vy) : CORD_W'(vy);
            n_m[l][0] = (CORD_W'(vx) > vay) ? CORD_W'(vx) : vay;
            n_x[l][0] = vx;
            n_y[l][0] = vy;

            // scaling, coarse steps
            vn = '{m: r_m[l][0], x: r_x[l][0], y: r_y[l][0]};
            vn = f_nrm(vn, 32);
            vn = f_nrm(vn, 16);
            vn = f_nrm(vn, 8);
            n_m[l][1]   = vn.m;
            n_x[l][1]   = vn.x;
            n_y[l][1]   = vn.y;
            n_acc[l][1] = r_acc[l][0];
            n_fix[l][1] = r_fix[l][0];

            // scaling, fine steps
            vn = '{m: r_m[l][1], x: r_x[l][1], y: r_y[l][1]};
            vn = f_nrm(vn, 4);
            vn = f_nrm(vn, 2);
            vn = f_nrm(vn, 1);
            n_x[l][2]   = vn.x;
            n_y[l][2]   = vn.y;
            n_acc[l][2] = r_acc[l][1];
            n_fix[l][2] = r_fix[l][1];

            // micro-rotations
            for (int i = 0; i < ITER; i++) begin
                vxs = r_x[l][2+i] >>> i;
                vys = r_y[l][2+i] >>> i;
                if (r_y[l][2+i] > 0) begin
                    vx = r_x[l][2+i] + vys;
                    vy = r_y[l][2+i] - vxs;
                    n_acc[l][3+i] = r_acc[l][2+i] + atan_tab(5'(i));
                end else begin
                    vx = r_x[l][2+i] - vys;
                    vy = r_y[l][2+i] + vxs;
                    n_acc[l][3+i] = r_acc[l][2+i] - atan_tab(5'(i));
                end
                if (r_fix[l][2+i]) begin
                    n_acc[l][3+i] = r_acc[l][2+i];
                end
                if (i < ITER - 1) begin
                    n_x[l][3+i]   = vx;
                    n_y[l][3+i]   = vy;
                    n_fix[l][3+i] = r_fix[l][2+i];
                end
            end

            vrnd     = r_acc[l][NAC-1] + ANG_ROUND;
            n_ang[l] = vrnd[ANG_W-1 -: BAM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            for (int k = 0; k < NXY; k++) begin
                if (w_rdy[k]) begin
                    r_x[l][k]   <= n_x[l][k];
                    r_y[l][k]   <= n_y[l][k];
                    r_fix[l][k] <= n_fix[l][k];
                end
            end
            for (int k = 0; k < NAC; k++) begin
                if (w_rdy[k]) begin
                    r_acc[l][k] <= n_acc[l][k];
                end
            end
            for (int k = 0; k < 2; k++) begin
                if (w_rdy[k]) begin
                    r_m[l][k] <= n_m[l][k];
                end
            end
            if (w_rdy[NS-1]) begin
                r_ang[l] <= n_ang[l];
            end
        end
        for (int k = 0; k < NS; k++) begin
            if (w_rdy[k]) begin
                r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k - 1];
            end
        end
    end

endmodule

// ----- rtl/core/qte_checker.sv -----
module qte_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [3*qte_pkg::BAM_W-1:0] m_axis_tdata,
    input logic [0:0]                  m_axis_tuser
);
    import qte_pkg::*;

    // no result the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a clamped sine gives pitch of exactly plus or minus pi/2
    a_clamp_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[2*BAM_W-1:BAM_W] == 16'h4000 ||
            m_axis_tdata[2*BAM_W-1:BAM_W] == 16'hC000)
        else $error("clamped pitch not at a pole");

endmodule

bind quaternion_to_euler_top qte_checker u_qte_checker (.*);

// ----- bench/qte_checker.sv -----
`timescale 1ns / 1ps
// watches both streams, predicts the three angles per quaternion, compares
module qte_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    import qte_pkg::*;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic        clamp;
    } t_angles;

    t_angles angle_q[$];

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    // arctangent of 2^-i as a 32-bit binary angle
    function automatic logic [31:0] atan_lut(int i);
        logic [31:0] t [0:15];
        t = '{32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
              32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
              32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
              32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D};
        return t[i];
    endfunction

    function automatic logic [31:0] vec_angle(longint y, longint x);
        logic [31:0] acc;
        longint xs, ys, mag, ax, ay;
        acc = 32'h0;
        if (x == 0 && y == 0) return 32'h0;
        if (x == 0) return (y > 0) ? 32'h4000_0000 : 32'hC000_0000;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
        end
        ax = x;
        ay = (y < 0) ? -y : y;
        mag = (ax > ay) ? ax : ay;
        while (mag < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
            mag = mag * 2;
        end
        for (int i = 0; i < 16; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                acc = acc + atan_lut(i);
            end else begin
                x = x - ys;
                y = y + xs;
                acc = acc - atan_lut(i);
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] to_bam(logic [31:0] a);
        logic [31:0] r;
        r = a + 32'h8000;
        return r[31:16];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // products are already q.30 for 16-bit components
    function automatic t_angles euler_of(logic [63:0] d);
        longint s, a, b, c, ry, rx, yy, yx, sn, sa, cs;
        t_angles r;
        s = longint'($signed(d[15:0]));
        a = longint'($signed(d[31:16]));
        b = longint'($signed(d[47:32]));
        c = longint'($signed(d[63:48]));
        ry = 2 * (b * c + s * a);
        rx = s * s - a * a - b * b + c * c;
        yy = 2 * (a * b + s * c);
        yx = s * s + a * a - b * b - c * c;
        sn = 2 * (s * b - a * c);
        r.clamp = 1'b0;
        if (sn > (64'sd1 <<< 30)) begin
            sn = 64'sd1 <<< 30;
            r.clamp = 1'b1;
        end else if (sn < -(64'sd1 <<< 30)) begin
            sn = -(64'sd1 <<< 30);
            r.clamp = 1'b1;
        end
        sa = (sn < 0) ? -sn : sn;
        cs = longint'(int_sqrt((64'd1 << 60) - sa * sa));
        r.roll  = to_bam(vec_angle(ry, rx));
        r.pitch = to_bam(vec_angle(sn, cs));
        r.yaw   = to_bam(vec_angle(yy, yx));
        return r;
    endfunction

    t_angles got, want;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_results <= 0;
            o_pending <= 0;
            angle_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) angle_q.push_back(euler_of(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                o_results <= o_results + 1;
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                       m_axis_tuser[0]};
                if (angle_q.size() == 0) begin
                    $display("%0t unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = angle_q.pop_front();
                    if (got != want) begin
                        $display("%0t mismatch roll %h/%h pitch %h/%h yaw %h/%h clamp %b/%b",
                                 $time, want.roll, got.roll, want.pitch, got.pitch,
                                 want.yaw, got.yaw, want.clamp, got.clamp);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= angle_q.size();
        end
    end

endmodule

// ----- bench/tb_quaternion_to_euler_top.sv -----
`timescale 1ns / 1ps
// stimulus and verdict for the quaternion converter
module tb_quaternion_to_euler_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;    // quat_scalar, quat_i, quat_j, quat_k
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;    // roll_angle, pitch_angle, yaw_angle
    logic [0:0]  m_axis_tuser;    // pitch_clamped
    int          errors, pending, results;
    logic        calm;            // no idling on either side while set
    logic [63:0] quat_list[$];

    quaternion_to_euler_top i_dut (.*);

    qte_scoreboard u_check (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver stalls at random, about 22 percent of the time, unless in the calm stretch
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 22);
    end

    // roughly unit quaternion with random signs, well-formed input
    function automatic logic [63:0] unit_quat();
        int c [4];
        int big;
        big = $urandom_range(3);
        for (int k = 0; k < 4; k++) c[k] = $urandom_range(16000) - 8000;
        c[big] = ($urandom_range(1) ? 1 : -1) * $urandom_range(32767, 20000);
        return {c[3][15:0], c[2][15:0], c[1][15:0], c[0][15:0]};
    endfunction

    initial begin
        logic [15:0] m, z, p, n;
        m = 16'h8000; z = 16'h0; p = 16'h7FFF; n = 16'hFFFF;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        calm = 1'b0;
        // directed: zero, identity, axes, extremes, positive clamp, pi results
        quat_list = '{ {z, z, z, z}, {z, z, z, p}, {z, z, p, z}, {z, p, z, z},
                       {p, z, z, z}, {z, z, z, m}, {m, z, z, z}, {z, m, z, z},
                       {p, p, p, p}, {m, m, m, m}, {m, p, m, p}, {p, m, p, m},
                       {z, p, z, p}, {m, z, p, z}, {z, z, z, 16'h5A82},
                       {16'h5A82, z, 16'h5A82, z}, {16'h5A82, z, 16'hA57E, z},
                       {n, n, n, n}, {16'h0001, z, z, z}, {z, 16'h0001, z, n},
                       {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555} };
        for (int k = 0; k < 530; k++)
            quat_list.push_back(($urandom_range(99) < 75) ? unit_quat()
                                : {$urandom(), $urandom()});
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (quat_list[k]) begin
            calm <= (k >= 250 && k < 350);
            while (!calm && $urandom_range(99) < 22) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= quat_list[k];
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b0;
        calm <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("covered %0d quaternions (extremes, axes, clamped pitch, random)",
                 quat_list.size());
        $display("%0d results checked with random gaps on both streams", results);
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ----- quaternion_to_euler_top.f -----
rtl/core/qte_pkg.sv
rtl/core/qte_front.sv
rtl/core/qte_isqrt.sv
rtl/core/qte_cordic.sv
rtl/core/quaternion_to_euler_top.sv
rtl/core/qte_checker.sv
bench/qte_checker.sv
bench/tb_quaternion_to_euler_top.sv
